/* rtl/tmr_pkg.sv */
package tmr_pkg;

  localparam int TOPICS      = 32;
  localparam int QUEUE_MAX   = 8;
  localparam int DATA_WIDTH  = 64;
  localparam int SUBSCRIBERS = 16;

  localparam int TOPIC_W = $clog2(TOPICS);
  localparam int SLOT_W  = $clog2(QUEUE_MAX);
  localparam int DEPTH_W = 4;
  localparam int SUB_W   = 4;
  localparam int CNT_W   = $clog2(SUBSCRIBERS) + 1;
  localparam int TCNT_W  = 6;
  localparam int ADDR_W  = TOPIC_W + SLOT_W;
  localparam int WORDS   = TOPICS * QUEUE_MAX;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DEPTH_W-1:0] RESET_QUEUE_LENGTH = DEPTH_W'(1);
  localparam logic [TCNT_W-1:0]  RESET_TOPIC_COUNT  = TCNT_W'(20);
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT        = DEPTH_W'(QUEUE_MAX);

  typedef enum logic [0:0] {
    REG_QUEUE_LENGTH = 1'b0,
    REG_TOPIC_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_PUBLISH,
    OP_READ,
    OP_CHECK,
    OP_ATTACH,
    OP_FAIL
  } op_t;

  localparam logic [1:0] KIND_PUBLISH = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_CHECK   = 2'd2;
  localparam logic [1:0] KIND_ATTACH  = 2'd3;

  typedef struct packed {
    op_t                   op;
    logic [TOPIC_W-1:0]    topic;
    logic [SUB_W-1:0]      sub;
    logic [DATA_WIDTH-1:0] word;
  } entry_t;

  // slot re-initialization request sent to the back part on a depth write
  typedef struct packed {
    logic              init;
    logic [SLOT_W-1:0] read_slot;
  } slot_init_t;

endpackage

/* rtl/tmr_front.sv */
module tmr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [tmr_pkg::TCNT_W-1:0]    cfg_data,
  input  logic                          accept,
  input  logic [1:0]                    kind,
  input  logic [tmr_pkg::TOPIC_W-1:0]   topic,
  input  logic [tmr_pkg::SUB_W-1:0]     subscriber,
  input  logic [tmr_pkg::DATA_WIDTH-1:0] payload,
  output logic                          push,
  output tmr_pkg::entry_t               entry,
  output logic [tmr_pkg::DEPTH_W-1:0]   depth,
  output tmr_pkg::slot_init_t           slot_init
);

  logic [tmr_pkg::DEPTH_W-1:0] queue_length;
  logic [tmr_pkg::TCNT_W-1:0]  topic_count;
  logic [tmr_pkg::DEPTH_W-1:0] new_len;
  logic [tmr_pkg::DEPTH_W-1:0] new_depth;
  logic                        topic_ok;
  logic                        depth_ok;
  logic                        sub_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length <= tmr_pkg::RESET_QUEUE_LENGTH;
      topic_count  <= tmr_pkg::RESET_TOPIC_COUNT;
    end else if (cfg_we) begin
      case (tmr_pkg::cfg_reg_t'(cfg_index))
        tmr_pkg::REG_QUEUE_LENGTH: queue_length <= new_len;
        tmr_pkg::REG_TOPIC_COUNT:  topic_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign new_len   = cfg_data[tmr_pkg::DEPTH_W-1:0];
  assign new_depth = (new_len > tmr_pkg::DEPTH_LIMIT) ? tmr_pkg::DEPTH_LIMIT : new_len;
  assign depth     = (queue_length > tmr_pkg::DEPTH_LIMIT) ? tmr_pkg::DEPTH_LIMIT
                                                           : queue_length;

  always_comb begin
    slot_init.init      = cfg_we && (tmr_pkg::cfg_reg_t'(cfg_index) == tmr_pkg::REG_QUEUE_LENGTH);
    slot_init.read_slot = '0;
    if (new_depth != '0) begin
      slot_init.read_slot = tmr_pkg::SLOT_W'(new_depth - tmr_pkg::DEPTH_W'(1));
    end
  end

  // topic count may exceed the topic range, then every topic is present
  assign topic_ok = {1'b0, topic} < topic_count;
  assign depth_ok = depth != '0;
  assign sub_ok   = {1'b0, subscriber} < (tmr_pkg::SUB_W + 1)'(tmr_pkg::SUBSCRIBERS);

  always_comb begin
    entry.topic = topic;
    entry.sub   = subscriber;
    entry.word  = payload;
    entry.op    = tmr_pkg::OP_FAIL;
    if (topic_ok) begin
      case (kind)
        tmr_pkg::KIND_PUBLISH: if (depth_ok) entry.op = tmr_pkg::OP_PUBLISH;
        tmr_pkg::KIND_READ:    if (depth_ok && sub_ok) entry.op = tmr_pkg::OP_READ;
        tmr_pkg::KIND_CHECK:   if (depth_ok && sub_ok) entry.op = tmr_pkg::OP_CHECK;
        tmr_pkg::KIND_ATTACH:  entry.op = tmr_pkg::OP_ATTACH;
        default:               entry.op = tmr_pkg::OP_FAIL;
      endcase
    end
  end

  assign push = accept;

endmodule

/* rtl/tmr_queue.sv */
module tmr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tmr_pkg::entry_t push_entry,
  output logic            full,
  output logic            nonempty,
  input  logic            pop,
  output tmr_pkg::entry_t head
);

  tmr_pkg::entry_t             slots [tmr_pkg::QUEUE_DEPTH];
  logic [tmr_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tmr_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tmr_pkg::QCNT_W-1:0]  count;

  assign full     = count == tmr_pkg::QCNT_W'(tmr_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tmr_pkg::QPTR_W'(tmr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tmr_pkg::QPTR_W'(tmr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/tmr_back.sv */
module tmr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           nonempty,
  input  tmr_pkg::entry_t                head,
  output logic                           pop,
  input  logic [tmr_pkg::DEPTH_W-1:0]    depth,
  input  tmr_pkg::slot_init_t            slot_init,
  output logic                           done,
  output logic                           status,
  output logic [tmr_pkg::DATA_WIDTH-1:0] read_word,
  output logic                           has_update,
  output logic [tmr_pkg::SUB_W-1:0]      assigned_id
);

  logic [tmr_pkg::DATA_WIDTH-1:0]  ring_store [tmr_pkg::WORDS];
  logic [tmr_pkg::WORDS-1:0]       word_valid;
  logic [tmr_pkg::SLOT_W-1:0]      write_slot [tmr_pkg::TOPICS];
  logic [tmr_pkg::SLOT_W-1:0]      read_slot  [tmr_pkg::TOPICS];
  logic [tmr_pkg::SUBSCRIBERS-1:0] fresh_mask [tmr_pkg::TOPICS];
  logic [tmr_pkg::CNT_W-1:0]       attached_count [tmr_pkg::TOPICS];

  logic [tmr_pkg::SLOT_W-1:0]     push_slot;
  logic [tmr_pkg::SLOT_W-1:0]     pop_slot;
  logic [tmr_pkg::SLOT_W-1:0]     push_next;
  logic [tmr_pkg::SLOT_W-1:0]     pop_next;
  logic [tmr_pkg::DEPTH_W-1:0]    last_slot;
  logic [tmr_pkg::ADDR_W-1:0]     waddr;
  logic [tmr_pkg::ADDR_W-1:0]     raddr;
  logic                           do_publish;
  logic                           do_read;
  logic                           do_attach;
  logic                           attach_ok;
  logic                           step_status;
  logic                           step_update;
  logic [tmr_pkg::SUB_W-1:0]      step_id;
  logic [tmr_pkg::DATA_WIDTH-1:0] rdata;
  logic                           rd_sel;
  logic                           rd_valid;

  assign pop = nonempty;

  assign push_slot = write_slot[head.topic];
  assign pop_slot  = read_slot[head.topic];
  assign last_slot = depth - tmr_pkg::DEPTH_W'(1);
  assign push_next = ({1'b0, push_slot} == last_slot) ? '0 : push_slot + 1'b1;
  assign pop_next  = ({1'b0, pop_slot} == last_slot) ? '0 : pop_slot + 1'b1;
  assign waddr     = {head.topic, push_slot};
  assign raddr     = {head.topic, pop_slot};
  assign attach_ok = attached_count[head.topic] <
                     tmr_pkg::CNT_W'(tmr_pkg::SUBSCRIBERS);

  assign do_publish = pop && (head.op == tmr_pkg::OP_PUBLISH);
  assign do_read    = pop && (head.op == tmr_pkg::OP_READ);
  assign do_attach  = pop && (head.op == tmr_pkg::OP_ATTACH) && attach_ok;

  always_comb begin
    step_status = 1'b0;
    step_update = 1'b0;
    step_id     = '0;
    case (head.op)
      tmr_pkg::OP_PUBLISH: ;
      tmr_pkg::OP_READ:    ;
      tmr_pkg::OP_CHECK:   step_update = fresh_mask[head.topic][head.sub];
      tmr_pkg::OP_ATTACH: begin
        step_status = !attach_ok;
        if (attach_ok) step_id = attached_count[head.topic][tmr_pkg::SUB_W-1:0];
      end
      default:             step_status = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_publish) begin
      ring_store[waddr] <= head.word;
    end
    rdata <= ring_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      for (int t = 0; t < tmr_pkg::TOPICS; t++) begin
        write_slot[t]     <= '0;
        read_slot[t]      <= tmr_pkg::SLOT_W'(tmr_pkg::RESET_QUEUE_LENGTH - 1'b1);
        fresh_mask[t]     <= '0;
        attached_count[t] <= '0;
      end
    end else begin
      if (slot_init.init) begin
        for (int t = 0; t < tmr_pkg::TOPICS; t++) begin
          write_slot[t] <= '0;
          read_slot[t]  <= slot_init.read_slot;
        end
      end else if (do_publish) begin
        word_valid[waddr]         <= 1'b1;
        write_slot[head.topic]    <= push_next;
        fresh_mask[head.topic]    <= '1;
        // ring full: drop the oldest word
        if (push_next == pop_slot) begin
          read_slot[head.topic] <= pop_next;
        end
      end else if (do_read) begin
        // newest word stays put, the reader is just marked as caught up
        if (pop_next == push_slot) begin
          fresh_mask[head.topic][head.sub] <= 1'b0;
        end else begin
          read_slot[head.topic] <= pop_next;
        end
      end else if (do_attach) begin
        attached_count[head.topic] <= attached_count[head.topic] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pop;
    end
  end

  always_ff @(posedge clk) begin
    status      <= step_status;
    has_update  <= step_update;
    assigned_id <= step_id;
    rd_sel      <= do_read;
    rd_valid    <= word_valid[raddr];
  end

  assign read_word = (rd_sel && rd_valid) ? rdata : '0;

`ifndef SYNTHESIS
  a_done_follows_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> done)
    else $error("result beat missing after execute");

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    !pop |=> !done)
    else $error("result beat without execute");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (read_word == '0 && !has_update && assigned_id == '0))
    else $error("failed beat carries data");

  a_slots_in_range: assert property (@(posedge clk) disable iff (rst)
    (pop && depth != '0 && !$past(slot_init.init)) |->
      ({1'b0, push_slot} < depth && {1'b0, pop_slot} < depth))
    else $error("slot beyond ring depth");
`endif

endmodule

/* rtl/topic_mailbox_ring.sv */
// channel   signals                                       direction
// command   start, busy, kind, topic, subscriber, payload  in (taken on start & !busy)
// result    done, status, read_word, has_update, assigned_id  out (one cycle per beat)
// config    cfg_we, cfg_index, cfg_data                   in (taken on cfg_we)
//
// a command is classified on acceptance and parked in a two-entry queue
// the back end executes one queued command per cycle; its result beat is
// registered and follows in the next cycle, so sustained rate is one per cycle
// busy is high only while the queue is full; done cannot be stalled
// rst is synchronous; all ring word valid bits, update masks and attach counts clear at once
module topic_mailbox_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     kind,
  input  logic [tmr_pkg::TOPIC_W-1:0]    topic,
  input  logic [tmr_pkg::SUB_W-1:0]      subscriber,
  input  logic [tmr_pkg::DATA_WIDTH-1:0] payload,
  output logic                           done,
  output logic                           status,
  output logic [tmr_pkg::DATA_WIDTH-1:0] read_word,
  output logic                           has_update,
  output logic [tmr_pkg::SUB_W-1:0]      assigned_id,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [tmr_pkg::TCNT_W-1:0]     cfg_data
);

  logic                        accept;
  logic                        push;
  logic                        pop;
  logic                        full;
  logic                        nonempty;
  tmr_pkg::entry_t             entry;
  tmr_pkg::entry_t             head;
  logic [tmr_pkg::DEPTH_W-1:0] depth;
  tmr_pkg::slot_init_t         slot_init;

  assign busy   = full;
  assign accept = start && !full;

  tmr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .kind       (kind),
    .topic      (topic),
    .subscriber (subscriber),
    .payload    (payload),
    .push       (push),
    .entry      (entry),
    .depth      (depth),
    .slot_init  (slot_init)
  );

  tmr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .full       (full),
    .nonempty   (nonempty),
    .pop        (pop),
    .head       (head)
  );

  tmr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .nonempty    (nonempty),
    .head        (head),
    .pop         (pop),
    .depth       (depth),
    .slot_init   (slot_init),
    .done        (done),
    .status      (status),
    .read_word   (read_word),
    .has_update  (has_update),
    .assigned_id (assigned_id)
  );

endmodule
